FILE: sv/psr_pkg.sv
package psr_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_TOP   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_GLITCH_THR = 3'd0;
    localparam logic [2:0] REG_SPEED_FAC  = 3'd1;
    localparam logic [2:0] REG_TARGET     = 3'd2;
    localparam logic [2:0] REG_GAIN_P     = 3'd3;
    localparam logic [2:0] REG_GAIN_I     = 3'd4;
    localparam logic [2:0] REG_INT_LIMIT  = 3'd5;
    localparam logic [2:0] REG_DRIVE_MAX  = 3'd6;
    localparam logic [2:0] REG_DRIVE_MIN  = 3'd7;

    // Reset values
    localparam logic [15:0] RST_GLITCH_THR = 16'd100;
    localparam logic [31:0] RST_SPEED_FAC  = 32'd0;
    localparam logic [15:0] RST_TARGET     = 16'd0;
    localparam logic [15:0] RST_GAIN_P     = 16'd4096;
    localparam logic [15:0] RST_GAIN_I     = 16'd0;
    localparam logic [22:0] RST_INT_LIMIT  = 23'd2560;
    localparam logic [15:0] RST_DRIVE_MAX  = 16'hFFFF;
    localparam logic [15:0] RST_DRIVE_MIN  = 16'd0;

    // One quotient bit per divider step
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [15:0] glitch_thr;
        logic [31:0] speed_fac;
        logic [15:0] target;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [22:0] int_limit;
        logic [15:0] drive_max;
        logic [15:0] drive_min;
    } t_cfg;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] speed;
        logic [15:0] drive;
        logic        restart;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL_I,
        S_INTEG,
        S_CTL,
        S_DONE
    } t_state;

endpackage

FILE: sv/psr_cfg.sv
module psr_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  logic [2:0]     i_index,
    input  logic [31:0]    i_data,
    output psr_pkg::t_cfg  o_cfg
);

    psr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glitch_thr <= psr_pkg::RST_GLITCH_THR;
            r_cfg.speed_fac  <= psr_pkg::RST_SPEED_FAC;
            r_cfg.target     <= psr_pkg::RST_TARGET;
            r_cfg.gain_p     <= psr_pkg::RST_GAIN_P;
            r_cfg.gain_i     <= psr_pkg::RST_GAIN_I;
            r_cfg.int_limit  <= psr_pkg::RST_INT_LIMIT;
            r_cfg.drive_max  <= psr_pkg::RST_DRIVE_MAX;
            r_cfg.drive_min  <= psr_pkg::RST_DRIVE_MIN;
        end else if (i_we) begin
            unique case (i_index)
                psr_pkg::REG_GLITCH_THR: r_cfg.glitch_thr <= i_data[15:0];
                psr_pkg::REG_SPEED_FAC:  r_cfg.speed_fac  <= i_data;
                psr_pkg::REG_TARGET:     r_cfg.target     <= i_data[15:0];
                psr_pkg::REG_GAIN_P:     r_cfg.gain_p     <= i_data[15:0];
                psr_pkg::REG_GAIN_I:     r_cfg.gain_i     <= i_data[15:0];
                psr_pkg::REG_INT_LIMIT:  r_cfg.int_limit  <= i_data[22:0];
                psr_pkg::REG_DRIVE_MAX:  r_cfg.drive_max  <= i_data[15:0];
                psr_pkg::REG_DRIVE_MIN:  r_cfg.drive_min  <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/psr_engine.sv
module psr_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psr_pkg::t_cfg    i_cfg,
    input  logic             i_start,
    input  logic [1:0]       i_cmd,
    input  logic             i_level_high,
    input  logic [15:0]      i_elapsed_count,
    output logic             o_ready,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output psr_pkg::t_result o_res
);

    psr_pkg::t_state r_state, n_state;

    logic [1:0]         r_cmd;
    logic               r_restart;
    logic [15:0]        r_period;
    logic [15:0]        r_rem;
    logic [15:0]        r_quo;     // dividend low half, then quotient / speed
    logic [3:0]         r_cnt;
    logic signed [33:0] r_prod;
    logic signed [23:0] r_integ;
    logic [15:0]        r_drive;

    logic               accept_top;
    logic               div_last;
    logic [16:0]        div_trial;
    logic [16:0]        div_diff;
    logic               div_ge;
    logic signed [16:0] err;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic signed [24:0] integ_sum;
    logic signed [24:0] lim_pos;
    logic signed [24:0] lim_neg;
    logic signed [23:0] integ_clamped;
    logic signed [26:0] ctl;

    assign accept_top = (i_cmd == psr_pkg::CMD_TOP) && i_level_high
                        && (i_elapsed_count > i_cfg.glitch_thr);
    assign div_last   = (r_cnt == 4'(psr_pkg::DIV_STEPS - 1));

    // Restoring divider step; remainder stays below the period
    assign div_trial = {r_rem, r_quo[15]};
    assign div_diff  = div_trial - {1'b0, r_period};
    assign div_ge    = (div_trial >= {1'b0, r_period});

    // Shared signed multiplier: error times one gain
    assign err   = $signed({1'b0, r_quo}) - $signed({1'b0, i_cfg.target});
    assign mul_b = (r_state == psr_pkg::S_MUL_I) ? $signed({1'b0, i_cfg.gain_i})
                                                 : $signed({1'b0, i_cfg.gain_p});
    assign mul_p = err * mul_b;

    // Integral update, floor of the Q.20 product by arithmetic shift
    assign integ_sum = 25'(r_integ) + 25'($signed(r_prod[33:12]));
    assign lim_pos   = $signed({2'b00, i_cfg.int_limit});
    assign lim_neg   = -lim_pos;
    always_comb begin
        if (integ_sum > lim_pos) begin
            integ_clamped = 24'(lim_pos);
        end else if (integ_sum < lim_neg) begin
            integ_clamped = 24'(lim_neg);
        end else begin
            integ_clamped = 24'(integ_sum);
        end
    end

    assign ctl = $signed({11'd0, i_cfg.target}) - 27'($signed(r_prod[33:12]))
                 - 27'(r_integ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            psr_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) n_state = psr_pkg::S_PREP;
            end
            psr_pkg::S_PREP: begin
                if (r_period == 16'd0 || i_cfg.speed_fac[31:16] >= r_period) begin
                    n_state = (r_cmd == psr_pkg::CMD_TICK) ? psr_pkg::S_MUL_I
                                                           : psr_pkg::S_DONE;
                end else begin
                    n_state = psr_pkg::S_DIV;
                end
            end
            psr_pkg::S_DIV: begin
                if (div_last) begin
                    n_state = (r_cmd == psr_pkg::CMD_TICK) ? psr_pkg::S_MUL_I
                                                           : psr_pkg::S_DONE;
                end
            end
            psr_pkg::S_MUL_I: n_state = psr_pkg::S_INTEG;
            psr_pkg::S_INTEG: n_state = psr_pkg::S_CTL;
            psr_pkg::S_CTL:   n_state = psr_pkg::S_DONE;
            psr_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) n_state = psr_pkg::S_IDLE;
            end
            default: n_state = psr_pkg::S_IDLE;
        endcase
    end

    // Control-loop state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 16'd0;
            r_integ   <= 24'sd0;
            r_drive   <= 16'd0;
            r_restart <= 1'b0;
        end else begin
            if (r_state == psr_pkg::S_IDLE && i_start) begin
                r_restart <= accept_top;
                if (accept_top) begin
                    r_period <= i_elapsed_count;
                end else if (i_cmd == psr_pkg::CMD_START) begin
                    r_period <= 16'd0;
                end
            end
            if (r_state == psr_pkg::S_INTEG) r_integ <= integ_clamped;
            if (r_state == psr_pkg::S_CTL) begin
                if (ctl > $signed({11'd0, i_cfg.drive_max})) begin
                    r_drive <= i_cfg.drive_max;
                end else if (ctl < $signed({11'd0, i_cfg.drive_min})) begin
                    r_drive <= i_cfg.drive_min;
                end else begin
                    r_drive <= ctl[15:0];
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            psr_pkg::S_IDLE: begin
                r_cmd <= i_cmd;
            end
            psr_pkg::S_PREP: begin
                r_cnt <= 4'd0;
                if (r_period == 16'd0) begin
                    r_quo <= 16'd0;
                end else if (i_cfg.speed_fac[31:16] >= r_period) begin
                    r_quo <= 16'hFFFF;
                end else begin
                    r_rem <= i_cfg.speed_fac[31:16];
                    r_quo <= i_cfg.speed_fac[15:0];
                end
            end
            psr_pkg::S_DIV: begin
                r_rem <= div_ge ? div_diff[15:0] : div_trial[15:0];
                r_quo <= {r_quo[14:0], div_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            psr_pkg::S_MUL_I, psr_pkg::S_INTEG: begin
                r_prod <= mul_p;
            end
            default: ;
        endcase
    end

    assign o_res.period  = r_period;
    assign o_res.speed   = r_quo;
    assign o_res.drive   = r_drive;
    assign o_res.restart = r_restart;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != psr_pkg::S_IDLE) |-> !o_ready)
        else $error("engine ready while busy");

    a_restart_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_restart) |-> (r_cmd == psr_pkg::CMD_TOP && r_period != 16'd0))
        else $error("restart without accepted top event");

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psr_pkg::S_CTL) |->
            (25'(r_integ) <= lim_pos && 25'(r_integ) >= lim_neg))
        else $error("integral outside limit");

    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == psr_pkg::S_DONE) && $past(r_state == psr_pkg::S_CTL)
         && i_cfg.drive_min <= i_cfg.drive_max) |->
            (r_drive >= i_cfg.drive_min && r_drive <= i_cfg.drive_max))
        else $error("drive outside clamp");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psr_pkg::S_DIV && !div_last) |=> (r_state == psr_pkg::S_DIV))
        else $error("divider left early");

endmodule

FILE: sv/period_speed_pi_regulator_top.sv
// A beat passes through prep and the 16-step restoring divider, and for a control tick
//   through the I product, the integral update with the P product and the drive clamp;
//   the divider is skipped when the period is zero or the quotient saturates.
// The engine takes no new beat until its result has moved to the output register.
// Reset (synchronous, active low): registers to defaults, period, integral and drive to 0.
module period_speed_pi_regulator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_level_high,
    input  logic [15:0] i_elapsed_count,
    // result beat
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_period_count,
    output logic [15:0] o_speed_now,
    output logic [15:0] o_drive_value,
    output logic        o_restart_timer,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    psr_pkg::t_cfg    cfg;
    psr_pkg::t_result eng_res;
    logic             eng_ready;
    logic             eng_res_valid;
    logic             out_load;

    psr_pkg::t_result r_out;
    logic             r_out_valid;

    // Registers are always writable; the user must make writes only while idle, unenforced.
    assign o_cfg_ready = 1'b1;

    psr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Engine takes a beat only in its idle state; it works through period update, division
    // and, for a tick, two multiplies and the clamps one step a cycle, then waits in done.
    assign o_stall = !eng_ready;

    psr_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_start         (i_valid && eng_ready),
        .i_cmd           (i_cmd),
        .i_level_high    (i_level_high),
        .i_elapsed_count (i_elapsed_count),
        .o_ready         (eng_ready),
        .o_res_valid     (eng_res_valid),
        .i_res_take      (out_load),
        .o_res           (eng_res)
    );

    // Output register: decouples result delivery from the next input beat,
    // so a new beat is taken while a finished result still waits.
    assign out_load = eng_res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= eng_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_period_count  = r_out.period;
    assign o_speed_now     = r_out.speed;
    assign o_drive_value   = r_out.drive;
    assign o_restart_timer = r_out.restart;

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cmd 3 has no name in the package; the block treats it as a no-op
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Run shape
    localparam int PHASES      = 12;    // random phases, each with its own register set
    localparam int PHASE_BEATS = 152;   // input beats per random phase
    localparam int HOLD_PHASE  = 3;     // phase in which the sink holds off for a long stretch
    localparam int PAUSE_PHASE = 6;     // phase in which the source pauses until drained
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;  // cycles with no handshake at all before giving up
    localparam int TAIL_CYCLES = 40;    // longer than the longest result latency, so this is ample

    localparam psr_pkg::t_result ALL_CLEAR = '0;

    // ------------------------------------------------------------------
    // Block ports, inputs all known from time zero
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd           = psr_pkg::CMD_TOP;
    logic        i_level_high    = 1'b0;
    logic [15:0] i_elapsed_count = '0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [15:0] o_period_count;
    logic [15:0] o_speed_now;
    logic [15:0] o_drive_value;
    logic        o_restart_timer;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index     = psr_pkg::REG_GLITCH_THR;
    logic [31:0] i_cfg_data      = '0;

    period_speed_pi_regulator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_level_high    (i_level_high),
        .i_elapsed_count (i_elapsed_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_period_count  (o_period_count),
        .o_speed_now     (o_speed_now),
        .o_drive_value   (o_drive_value),
        .o_restart_timer (o_restart_timer),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Regulator model: shadow registers and state, updated at the edge
    // where a beat or a register write is taken.
    // ------------------------------------------------------------------
    psr_pkg::t_cfg cfg_sh;
    logic [15:0]   period_m;
    longint        integ_m;     // signed Q8.8, always inside +/- integral limit
    logic [15:0]   drive_m;

    psr_pkg::t_result reports_due[$];   // results still owed by the block, oldest first

    int          n_fail       = 0;
    int          quiet_cycles = 0;
    bit          idle_on      = 1'b1;   // random gaps on both sides
    bit          hold_req     = 1'b0;   // asks the sink for one long hold-off

    function automatic logic [15:0] speed_of(input logic [15:0] per);
        logic [31:0] q;
        if (per == '0)
            return '0;
        q = cfg_sh.speed_fac / {16'd0, per};
        return (q > 32'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // One beat through the PI law. Products are Q.20; an arithmetic shift
    // by 12 on a signed 64-bit value is the floor division back to Q8.8.
    function automatic psr_pkg::t_result regulator_step(input logic [1:0] c, input logic l,
                                                        input logic [15:0] n);
        psr_pkg::t_result r;
        longint  err;
        longint  sum;
        longint  ctl;
        longint  lim;
        r = ALL_CLEAR;
        case (c)
            psr_pkg::CMD_TOP: begin
                if (l && n > cfg_sh.glitch_thr) begin
                    period_m  = n;
                    r.restart = 1'b1;
                end
            end
            psr_pkg::CMD_START: period_m = '0;
            psr_pkg::CMD_TICK: begin
                err = longint'(speed_of(period_m)) - longint'(cfg_sh.target);
                lim = longint'(cfg_sh.int_limit);
                sum = integ_m + ((err * longint'(cfg_sh.gain_i)) >>> 12);
                if (sum > lim)
                    sum = lim;
                else if (sum < -lim)
                    sum = -lim;
                integ_m = sum;
                ctl = longint'(cfg_sh.target) - ((err * longint'(cfg_sh.gain_p)) >>> 12) - sum;
                // max test first, so crossed bounds give max when above it
                if (ctl > longint'(cfg_sh.drive_max))
                    ctl = longint'(cfg_sh.drive_max);
                else if (ctl < longint'(cfg_sh.drive_min))
                    ctl = longint'(cfg_sh.drive_min);
                drive_m = ctl[15:0];
            end
            default: ;
        endcase
        r.period = period_m;
        r.speed  = speed_of(period_m);
        r.drive  = drive_m;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Holds i_valid high after acceptance; the caller lowers it for a gap.
    task automatic send_beat(input logic [1:0] c, input logic l, input logic [15:0] n,
                             input bit known, input psr_pkg::t_result want);
        psr_pkg::t_result calc;
        i_valid         <= 1'b1;
        i_cmd           <= c;
        i_level_high    <= l;
        i_elapsed_count <= n;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        calc = regulator_step(c, l, n);
        reports_due.push_back(known ? want : calc);
    endtask

    // Leaves i_cfg_valid high so back-to-back writes need no re-raise.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            psr_pkg::REG_GLITCH_THR: cfg_sh.glitch_thr = d[15:0];
            psr_pkg::REG_SPEED_FAC:  cfg_sh.speed_fac  = d;
            psr_pkg::REG_TARGET:     cfg_sh.target     = d[15:0];
            psr_pkg::REG_GAIN_P:     cfg_sh.gain_p     = d[15:0];
            psr_pkg::REG_GAIN_I:     cfg_sh.gain_i     = d[15:0];
            psr_pkg::REG_INT_LIMIT:  cfg_sh.int_limit  = d[22:0];
            psr_pkg::REG_DRIVE_MAX:  cfg_sh.drive_max  = d[15:0];
            psr_pkg::REG_DRIVE_MIN:  cfg_sh.drive_min  = d[15:0];
            default: ;
        endcase
    endtask

    // Every beat gives exactly one result, so an empty queue means idle.
    task automatic wait_drained();
        if (i_valid)
            i_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Zero, all ones, or a random value scaled down to spread the magnitudes
    function automatic logic [31:0] draw_reg(input int unsigned w);
        logic [31:0] mask;
        mask = (w >= 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 32'd1;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return mask;
            default: return ($urandom & mask) >> $urandom_range(0, w / 2);
        endcase
    endfunction

    task automatic run_phase(input int p);
        logic [1:0]  c;
        logic        l;
        logic [15:0] n;
        int unsigned pick;
        wait_drained();
        write_reg(psr_pkg::REG_GLITCH_THR, draw_reg(16));
        write_reg(psr_pkg::REG_SPEED_FAC,  draw_reg(32));
        write_reg(psr_pkg::REG_TARGET,     draw_reg(16));
        write_reg(psr_pkg::REG_GAIN_P,     draw_reg(16));
        write_reg(psr_pkg::REG_GAIN_I,     draw_reg(16));
        write_reg(psr_pkg::REG_INT_LIMIT,  draw_reg(23));
        write_reg(psr_pkg::REG_DRIVE_MAX,  draw_reg(16));
        write_reg(psr_pkg::REG_DRIVE_MIN,  draw_reg(16));
        i_cfg_valid <= 1'b0;
        // last two phases run flat out on both sides
        idle_on = (p < PHASES - 2);
        if (p == HOLD_PHASE)
            hold_req = 1'b1;
        for (int k = 0; k < PHASE_BEATS; k++) begin
            if (p == PAUSE_PHASE && k == PHASE_BEATS / 2)
                wait_drained();
            // mostly tops and ticks, as on a spinning rotor; some starts and junk
            pick = $urandom_range(0, 99);
            c = (pick < 40) ? psr_pkg::CMD_TOP : (pick < 85) ? psr_pkg::CMD_TICK :
                (pick < 93) ? psr_pkg::CMD_START : CMD_UNUSED;
            l = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0:       n = 16'hFFFF;
                1:       n = 16'h0000;
                2:       n = cfg_sh.glitch_thr;           // one short of acceptance
                3:       n = cfg_sh.glitch_thr + 16'd1;   // just accepted
                default: n = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_beat(c, l, n, 1'b0, ALL_CLEAR);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [2:0]       idx;
        logic [31:0]      data;
        logic [1:0]       cmd;
        logic             lvl;
        logic [15:0]      cnt;
        bit               known;   // want is typed in rather than predicted
        psr_pkg::t_result want;
    } t_plan_row;

    function automatic t_plan_row beat_row(input logic [1:0] c, input logic l,
                                           input logic [15:0] n);
        t_plan_row r;
        r.kind  = ROW_BEAT;
        r.idx   = psr_pkg::REG_GLITCH_THR;
        r.data  = '0;
        r.cmd   = c;
        r.lvl   = l;
        r.cnt   = n;
        r.known = 1'b0;
        r.want  = ALL_CLEAR;
        return r;
    endfunction

    function automatic t_plan_row known_row(input logic [1:0] c, input logic l,
                                            input logic [15:0] n,
                                            input psr_pkg::t_result w);
        t_plan_row r;
        r       = beat_row(c, l, n);
        r.known = 1'b1;
        r.want  = w;
        return r;
    endfunction

    function automatic t_plan_row reg_row(input logic [2:0] idx, input logic [31:0] d);
        t_plan_row r;
        r      = beat_row(psr_pkg::CMD_TOP, 1'b0, '0);
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = d;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row plan[$];
        bit        reg_open;

        cfg_sh   = '{psr_pkg::RST_GLITCH_THR, psr_pkg::RST_SPEED_FAC, psr_pkg::RST_TARGET,
                     psr_pkg::RST_GAIN_P, psr_pkg::RST_GAIN_I, psr_pkg::RST_INT_LIMIT,
                     psr_pkg::RST_DRIVE_MAX, psr_pkg::RST_DRIVE_MIN};
        period_m = '0;
        integ_m  = 0;
        drive_m  = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: factor 0, so speed stays 0 whatever the period
        plan.push_back(known_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000, ALL_CLEAR));
        // count equal to threshold is not enough
        plan.push_back(known_row(psr_pkg::CMD_TOP, 1'b1, psr_pkg::RST_GLITCH_THR,
                                 ALL_CLEAR));
        // level low: ignored even at full count
        plan.push_back(known_row(psr_pkg::CMD_TOP, 1'b0, 16'hFFFF, ALL_CLEAR));
        plan.push_back(known_row(psr_pkg::CMD_TOP, 1'b1, psr_pkg::RST_GLITCH_THR + 16'd1,
            psr_pkg::t_result'{psr_pkg::RST_GLITCH_THR + 16'd1, 16'd0, 16'd0, 1'b1}));
        plan.push_back(known_row(psr_pkg::CMD_TOP, 1'b1, 16'hFFFF,
                                 psr_pkg::t_result'{16'hFFFF, 16'd0, 16'd0, 1'b1}));
        // unused command just reports
        plan.push_back(known_row(CMD_UNUSED, 1'b1, 16'hFFFF,
                                 psr_pkg::t_result'{16'hFFFF, 16'd0, 16'd0, 1'b0}));
        plan.push_back(known_row(psr_pkg::CMD_TICK, 1'b1, 16'h0000,
                                 psr_pkg::t_result'{16'hFFFF, 16'd0, 16'd0, 1'b0}));
        plan.push_back(known_row(psr_pkg::CMD_START, 1'b0, 16'h0000, ALL_CLEAR));
        // quotient saturates: 0xFFFFFFFF / 0xFFFF is above 16 bits
        plan.push_back(reg_row(psr_pkg::REG_SPEED_FAC, 32'hFFFF_FFFF));
        plan.push_back(known_row(psr_pkg::CMD_TOP, 1'b1, 16'hFFFF,
                                 psr_pkg::t_result'{16'hFFFF, 16'hFFFF, 16'd0, 1'b1}));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));
        // zero period with a full target: integral runs negative, drive to max
        plan.push_back(reg_row(psr_pkg::REG_TARGET, 32'h0000_FFFF));
        plan.push_back(reg_row(psr_pkg::REG_GAIN_I, 32'h0000_FFFF));
        plan.push_back(reg_row(psr_pkg::REG_INT_LIMIT, 32'h007F_FFFF));
        plan.push_back(reg_row(psr_pkg::REG_GAIN_P, 32'h0000_0000));
        plan.push_back(beat_row(psr_pkg::CMD_START, 1'b1, 16'hFFFF));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b1, 16'hFFFF));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));
        // integral clamped to nothing
        plan.push_back(reg_row(psr_pkg::REG_INT_LIMIT, 32'h0000_0000));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));
        // crossed clamp bounds, above the max
        plan.push_back(reg_row(psr_pkg::REG_DRIVE_MAX, 32'h0000_1000));
        plan.push_back(reg_row(psr_pkg::REG_DRIVE_MIN, 32'h0000_2000));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));
        // threshold extremes
        plan.push_back(reg_row(psr_pkg::REG_GLITCH_THR, 32'h0000_FFFF));
        plan.push_back(beat_row(psr_pkg::CMD_TOP, 1'b1, 16'hFFFF));
        plan.push_back(reg_row(psr_pkg::REG_GLITCH_THR, 32'h0000_0000));
        plan.push_back(beat_row(psr_pkg::CMD_TOP, 1'b1, 16'h0000));
        plan.push_back(beat_row(psr_pkg::CMD_TOP, 1'b1, 16'h0001));
        // fast rotor, target 0: integral positive, crossed bounds give the min
        plan.push_back(reg_row(psr_pkg::REG_TARGET, 32'h0000_0000));
        plan.push_back(reg_row(psr_pkg::REG_INT_LIMIT, 32'h007F_FFFF));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b1, 16'h8000));
        // full P gain on full error, normal bounds
        plan.push_back(reg_row(psr_pkg::REG_GAIN_P, 32'h0000_FFFF));
        plan.push_back(reg_row(psr_pkg::REG_DRIVE_MAX, 32'h0000_FFFF));
        plan.push_back(reg_row(psr_pkg::REG_DRIVE_MIN, 32'h0000_0000));
        plan.push_back(beat_row(psr_pkg::CMD_TICK, 1'b0, 16'h0000));

        reg_open = 1'b0;
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                // registers only change with the block empty
                if (!reg_open)
                    wait_drained();
                write_reg(plan[k].idx, plan[k].data);
                reg_open = 1'b1;
            end else begin
                if (reg_open)
                    i_cfg_valid <= 1'b0;
                reg_open = 1'b0;
                send_beat(plan[k].cmd, plan[k].lvl, plan[k].cnt, plan[k].known, plan[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_backpressure
        int unsigned burst;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: pre-edge values sampled at the edge of acceptance
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            n_fail++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        psr_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (reports_due.size() == 0) begin
                n_fail++;
                $display("%0t: result beat with nothing owed, expected none got %h %h %h %b",
                         $time, o_period_count, o_speed_now, o_drive_value,
                         o_restart_timer);
            end else begin
                want = reports_due.pop_front();
                check_field("period_count", want.period, o_period_count);
                check_field("speed_now", want.speed, o_speed_now);
                check_field("drive_value", want.drive, o_drive_value);
                check_field("restart_timer", {15'd0, want.restart}, {15'd0, o_restart_timer});
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on any channel counts as progress
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) ||
            (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results owed",
                     $time, quiet_cycles, reports_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
